// ===== hdl/ipv4dq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Types, codes and constants shared by the dotted-quad parser modules.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned AccW    = 9;
  localparam int unsigned FieldW  = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned NumOct  = 4;

  localparam logic [CharW-1:0]   CharNul   = 8'h00;
  localparam logic [CharW-1:0]   CharDot   = 8'h2E;
  localparam logic [CharW-1:0]   CharZero  = 8'h30;
  localparam logic [CharW-1:0]   CharNine  = 8'h39;

  localparam logic [AccW-1:0]    OctetMax  = 9'd255;
  localparam logic [AccW-1:0]    AccSat    = 9'd256;
  localparam logic [FieldW-1:0]  FieldInit = 3'd1;
  localparam logic [FieldW-1:0]  FieldSat  = 3'd5;
  localparam logic [FieldW-1:0]  FieldDone = 3'd4;

  localparam logic [StatusW-1:0] StBadFormat   = 2'd0;
  localparam logic [StatusW-1:0] StSuccess     = 2'd1;
  localparam logic [StatusW-1:0] StUnsupported = 2'd2;

  typedef struct packed {
    logic             fire;
    logic [CharW-1:0] character;
  } step_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   address;
  } result_t;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ipv4dq_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4dq_parser
// Field counter, octet accumulators and bad-character flag, plus the verdict
// formed on the terminator.
// ----------------------------------------------------------------------------
module ipv4dq_parser (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire ipv4dq_pkg::step_t  step,
  input  wire                     family_is_ipv4,
  output ipv4dq_pkg::result_t     result
);

  logic [ipv4dq_pkg::FieldW-1:0] field_r, field_nxt;
  logic [ipv4dq_pkg::AccW-1:0]   acc_r   [ipv4dq_pkg::NumOct];
  logic [ipv4dq_pkg::AccW-1:0]   acc_nxt [ipv4dq_pkg::NumOct];
  logic                          bad_r, bad_nxt;

  logic                          is_term;
  logic                          in_range;
  logic [1:0]                    oct_idx;
  logic [11:0]                   prod;
  logic [ipv4dq_pkg::AccW-1:0]   acc_upd;
  logic                          over;

  assign is_term  = (step.character == ipv4dq_pkg::CharNul);
  assign in_range = (field_r >= 3'd1) && (field_r <= 3'd4);
  assign oct_idx  = field_r[1:0] - 2'd1;

  // value * 10 + digit; the widest case stays below 4096.
  assign prod = {acc_r[oct_idx], 3'b000} + {2'b00, acc_r[oct_idx], 1'b0}
              + {8'h00, step.character[3:0]};
  assign acc_upd = (prod > {3'b000, ipv4dq_pkg::AccSat}) ? ipv4dq_pkg::AccSat
                                                         : prod[8:0];

  always_comb begin
    field_nxt = field_r;
    bad_nxt   = bad_r;
    for (int i = 0; i < ipv4dq_pkg::NumOct; i++) begin
      acc_nxt[i] = acc_r[i];
    end
    if (step.fire) begin
      if (is_term) begin
        field_nxt = ipv4dq_pkg::FieldInit;
        bad_nxt   = 1'b0;
        for (int i = 0; i < ipv4dq_pkg::NumOct; i++) begin
          acc_nxt[i] = '0;
        end
      end else if (step.character == ipv4dq_pkg::CharDot) begin
        if (field_r < ipv4dq_pkg::FieldSat) begin
          field_nxt = field_r + 3'd1;
        end
      end else if (ipv4dq_pkg::is_digit(step.character)) begin
        if (in_range) begin
          acc_nxt[oct_idx] = acc_upd;
        end
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= ipv4dq_pkg::FieldInit;
      bad_r   <= 1'b0;
      for (int i = 0; i < ipv4dq_pkg::NumOct; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      field_r <= field_nxt;
      bad_r   <= bad_nxt;
      for (int i = 0; i < ipv4dq_pkg::NumOct; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
    end
  end

  assign over = (acc_r[0] > ipv4dq_pkg::OctetMax) || (acc_r[1] > ipv4dq_pkg::OctetMax)
             || (acc_r[2] > ipv4dq_pkg::OctetMax) || (acc_r[3] > ipv4dq_pkg::OctetMax);

  always_comb begin
    result.status  = ipv4dq_pkg::StSuccess;
    result.address = {acc_r[3][7:0], acc_r[2][7:0], acc_r[1][7:0], acc_r[0][7:0]};
    if (!family_is_ipv4) begin
      result.status  = ipv4dq_pkg::StUnsupported;
      result.address = '0;
    end else if (bad_r || (field_r != ipv4dq_pkg::FieldDone) || over) begin
      result.status  = ipv4dq_pkg::StBadFormat;
      result.address = '0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ipv4dq_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4dq_out_reg
// Result register that holds one finished item until the consumer takes it.
// ----------------------------------------------------------------------------
module ipv4dq_out_reg (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                load,
  input  wire ipv4dq_pkg::result_t           result,
  output logic                               ready,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [ipv4dq_pkg::StatusW-1:0]     out_status,
  output logic [ipv4dq_pkg::AddrW-1:0]       out_address
);

  logic                 valid_r, valid_nxt;
  ipv4dq_pkg::result_t  data_r;

  // The register can take a new item when empty or when its item leaves now.
  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid   = valid_r;
  assign out_status  = data_r.status;
  assign out_address = data_r.address;

endmodule
`default_nettype wire

// ===== hdl/ipv4_dotted_quad_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_top
// Parses an IPv4 dotted-decimal string, one character per item, into a
// status and a 32-bit address with the first octet in bits 7:0.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                               Handshake
//  in       input      in_character                        in_valid / in_stall
//  out      output     out_status, out_address             out_valid / out_stall
//  cfg      input      cfg_wr_data (family_is_ipv4)        cfg_wr_en
//
// One character item is taken every cycle unless the input stalls. An item
// waits in the character register until it is applied to the parse state;
// a terminator's result is shown at the output from the edge applying it.
// Reset returns the parser to field one with empty octets and the family
// register to IPv4. The input stalls only while a terminator waits for the
// result register to free up; other characters never wait.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [ipv4dq_pkg::CharW-1:0]       in_character,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [ipv4dq_pkg::StatusW-1:0]     out_status,
  output logic [ipv4dq_pkg::AddrW-1:0]       out_address,
  input  wire                                cfg_wr_en,
  input  wire                                cfg_wr_data
);

  logic                          family_r;
  logic                          in_full_r, in_full_nxt;
  logic [ipv4dq_pkg::CharW-1:0]  char_r;
  logic                          term;
  logic                          advance;
  logic                          out_ready;
  ipv4dq_pkg::step_t             step;
  ipv4dq_pkg::result_t           result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      family_r <= 1'b1;
    end else if (cfg_wr_en) begin
      family_r <= cfg_wr_data;
    end
  end

  assign term    = (char_r == ipv4dq_pkg::CharNul);
  assign advance = in_full_r && (!term || out_ready);
  assign in_stall = in_full_r && !advance;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_valid && !in_stall) begin
      in_full_nxt = 1'b1;
    end else if (advance) begin
      in_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_character;
    end
  end

  assign step.fire      = advance;
  assign step.character = char_r;

  ipv4dq_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .family_is_ipv4 (family_r),
    .result         (result)
  );

  ipv4dq_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (advance && term),
    .result      (result),
    .ready       (out_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_address (out_address)
  );

  // A failed or refused parse never carries an address.
  a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ipv4dq_pkg::StSuccess) |-> (out_address == '0))
    else $error("nonzero address on a failed result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ipv4dq_pkg::StBadFormat)
               || (out_status == ipv4dq_pkg::StSuccess)
               || (out_status == ipv4dq_pkg::StUnsupported))
    else $error("undefined status code");

  // Only a terminator that meets a full, stalled result register holds the input.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_full_r && term && out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance && term |=> out_valid)
    else $error("terminator processed but no result shown");

endmodule
`default_nettype wire
